// ----- src/assert_macros.svh -----
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define DTPV_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define DTPV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/dtpv_pkg.sv -----
`timescale 1ns / 1ps
package dtpv_pkg;

  localparam int BRANCHES = 8;
  localparam int DEPTH    = 16;

  // field widths
  localparam int TOKEN_W     = 24;
  localparam int BRANCH_W    = 3;
  localparam int BCOUNT_W    = 4;
  localparam int DEPTH_OUT_W = 5;
  localparam int BLIMIT_W    = 4;
  localparam int DLIMIT_W    = 5;
  localparam int CFG_W       = 5;
  localparam int CFG_IDX_W   = 1;

  // derived widths
  localparam int BIDX_W = (BRANCHES > 1) ? $clog2(BRANCHES) : 1;
  localparam int PIDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(BRANCHES + 1);
  localparam int LEN_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = (BRANCHES * DEPTH > 1) ? $clog2(BRANCHES * DEPTH) : 1;

  localparam logic [CFG_IDX_W-1:0] REG_BRANCH_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_LIMIT  = 1'b1;

  localparam logic [BLIMIT_W-1:0] BLIMIT_RST = BLIMIT_W'(8);
  localparam logic [DLIMIT_W-1:0] DLIMIT_RST = DLIMIT_W'(16);

  typedef enum logic [1:0] {
    ACT_DRAFT  = 2'd0,
    ACT_AUTH   = 2'd1,
    ACT_VERIFY = 2'd2
  } action_e;

  typedef struct packed {
    action_e               action;
    logic [BRANCH_W-1:0]   branch;
    logic [TOKEN_W-1:0]    token;
    logic [BCOUNT_W-1:0]   branch_count;
  } in_t;

  typedef struct packed {
    logic [TOKEN_W-1:0]     token_out;
    logic                   token_valid;
    logic                   last;
    logic [BRANCH_W-1:0]    chosen_branch;
    logic [DEPTH_OUT_W-1:0] accepted_depth;
    logic [BRANCH_W-1:0]    rejected_branches;
    logic                   found_match;
    logic                   has_fallback;
    logic                   matches_path;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic vstart;
    logic br_start;
    logic rd_cmp;
    logic p_inc;
    logic br_end;
    logic sum;
    logic rd_emit;
    logic emit_tok;
    logic emit_sum;
    logic clear;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic br_done;
    logic p_lt_lim;
    logic tok_eq;
    logic total_zero;
    logic last_tok;
  } sts_t;

  function automatic logic [CNT_W-1:0] eff_branches(input logic [BLIMIT_W-1:0] lim);
    logic [CNT_W-1:0] r;
    if (lim == '0) begin
      r = CNT_W'(1);
    end else if (32'(lim) > 32'(BRANCHES)) begin
      r = CNT_W'(BRANCHES);
    end else begin
      r = CNT_W'(lim);
    end
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] eff_depth(input logic [DLIMIT_W-1:0] lim);
    logic [LEN_W-1:0] r;
    if (lim == '0) begin
      r = LEN_W'(1);
    end else if (32'(lim) > 32'(DEPTH)) begin
      r = LEN_W'(DEPTH);
    end else begin
      r = LEN_W'(lim);
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] draft_addr(input logic [BIDX_W-1:0] b,
                                                   input logic [PIDX_W-1:0] p);
    return ADDR_W'(b) * ADDR_W'(DEPTH) + ADDR_W'(p);
  endfunction

endpackage

// ----- src/dtpv_ram.sv -----
`timescale 1ns / 1ps
module dtpv_ram #(
  parameter int WIDTH = 24,
  parameter int WORDS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [WORDS];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/dtpv_ctrl.sv -----
`timescale 1ns / 1ps
module dtpv_ctrl import dtpv_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  action_e action_i,
  input  sts_t    sts_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_BR,
    S_RD,
    S_CK,
    S_BEND,
    S_SUM,
    S_ERD,
    S_EOUT
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;
  cmd_t   cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd.accept = 1'b1;
          if (action_i == ACT_VERIFY) begin
            cmd.vstart = 1'b1;
            state_d    = S_INIT;
          end
        end
      end
      S_INIT: begin
        if (sts_i.cnt_zero) begin
          cmd.emit_sum = 1'b1;
          cmd.clear    = 1'b1;
          state_d      = S_IDLE;
        end else begin
          state_d = S_BR;
        end
      end
      S_BR: begin
        if (sts_i.br_done) begin
          state_d = S_SUM;
        end else begin
          cmd.br_start = 1'b1;
          state_d      = S_RD;
        end
      end
      S_RD: begin
        if (sts_i.p_lt_lim) begin
          cmd.rd_cmp = 1'b1;
          state_d    = S_CK;
        end else begin
          state_d = S_BEND;
        end
      end
      S_CK: begin
        if (sts_i.tok_eq) begin
          cmd.p_inc = 1'b1;
          state_d   = S_RD;
        end else begin
          state_d = S_BEND;
        end
      end
      S_BEND: begin
        cmd.br_end = 1'b1;
        state_d    = S_BR;
      end
      S_SUM: begin
        cmd.sum = 1'b1;
        if (sts_i.total_zero) begin
          cmd.emit_sum = 1'b1;
          cmd.clear    = 1'b1;
          state_d      = S_IDLE;
        end else begin
          state_d = S_ERD;
        end
      end
      S_ERD: begin
        cmd.rd_emit = 1'b1;
        state_d     = S_EOUT;
      end
      S_EOUT: begin
        cmd.emit_tok = 1'b1;
        if (sts_i.last_tok) begin
          cmd.clear = 1'b1;
          state_d   = S_IDLE;
        end else begin
          state_d = S_ERD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

  assign cmd_o  = cmd;
  assign busy_o = busy_q;

endmodule

// ----- src/dtpv_dp.sv -----
`timescale 1ns / 1ps
module dtpv_dp import dtpv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  in_t                  in_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output out_t                 res_o,
  output logic                 res_strobe_o
);

  logic [BLIMIT_W-1:0] blim_q;
  logic [DLIMIT_W-1:0] dlim_q;
  logic [LEN_W-1:0]    lens_q [BRANCHES];
  logic [LEN_W-1:0]    auth_cnt_q;
  logic [CNT_W-1:0]    cnt_q, b_q;
  logic [LEN_W-1:0]    p_q, lim_q, best_len_q, best_blen_q, i_q, total_q;
  logic [BIDX_W-1:0]   best_q;
  logic                fb_q;
  out_t                res_q, res_d;
  logic                strobe_q;

  logic [CNT_W-1:0]  eff_br, cnt_in;
  logic [LEN_W-1:0]  eff_dep, lens_rd, lim_c, total_c;
  logic [BIDX_W-1:0] lens_idx;
  logic              draft_we, auth_we, fb_c;
  logic [ADDR_W-1:0] draft_waddr, draft_raddr;
  logic [PIDX_W-1:0] auth_waddr, auth_raddr;
  logic [TOKEN_W-1:0] draft_rd, auth_rd;

  assign eff_br   = eff_branches(blim_q);
  assign eff_dep  = eff_depth(dlim_q);
  assign cnt_in   = (32'(in_i.branch_count) > 32'(eff_br)) ? eff_br
                                                         : CNT_W'(in_i.branch_count);
  // one read port on the length table: load branch on an accepted transaction, walk index otherwise
  assign lens_idx = cmd_i.accept ? BIDX_W'(in_i.branch) : b_q[BIDX_W-1:0];
  assign lens_rd  = lens_q[lens_idx];
  assign lim_c    = (lens_rd < auth_cnt_q) ? lens_rd : auth_cnt_q;

  assign draft_we = cmd_i.accept && (in_i.action == ACT_DRAFT) &&
                    (32'(in_i.branch) < 32'(eff_br)) && (lens_rd < eff_dep);
  assign auth_we  = cmd_i.accept && (in_i.action == ACT_AUTH) &&
                    (auth_cnt_q < LEN_W'(DEPTH));

  assign draft_waddr = draft_addr(lens_idx, lens_rd[PIDX_W-1:0]);
  assign auth_waddr  = auth_cnt_q[PIDX_W-1:0];
  assign draft_raddr = cmd_i.rd_emit ? draft_addr(best_q, i_q[PIDX_W-1:0])
                                     : draft_addr(b_q[BIDX_W-1:0], p_q[PIDX_W-1:0]);
  assign auth_raddr  = cmd_i.rd_emit ? best_len_q[PIDX_W-1:0] : p_q[PIDX_W-1:0];

  dtpv_ram #(.WIDTH(TOKEN_W), .WORDS(BRANCHES * DEPTH)) u_draft_ram (
    .clk_i   (clk_i),
    .we_i    (draft_we),
    .waddr_i (draft_waddr),
    .wdata_i (in_i.token),
    .raddr_i (draft_raddr),
    .rdata_o (draft_rd)
  );

  dtpv_ram #(.WIDTH(TOKEN_W), .WORDS(DEPTH)) u_auth_ram (
    .clk_i   (clk_i),
    .we_i    (auth_we),
    .waddr_i (auth_waddr),
    .wdata_i (in_i.token),
    .raddr_i (auth_raddr),
    .rdata_o (auth_rd)
  );

  assign fb_c    = (best_len_q < auth_cnt_q) && (best_len_q < best_blen_q);
  assign total_c = best_len_q + LEN_W'(fb_c);

  always_comb begin
    sts_o.cnt_zero   = (cnt_q == '0);
    sts_o.br_done    = (b_q == cnt_q);
    sts_o.p_lt_lim   = (p_q < lim_q);
    sts_o.tok_eq     = (draft_rd == auth_rd);
    sts_o.total_zero = (total_c == '0);
    sts_o.last_tok   = ((i_q + LEN_W'(1)) == total_q);
  end

  // result word
  always_comb begin
    res_d = '0;
    if (cmd_i.emit_tok) begin
      res_d.token_valid = 1'b1;
      res_d.token_out   = (i_q < best_len_q) ? draft_rd : auth_rd;
    end
    if (cmd_i.emit_sum || (cmd_i.emit_tok && sts_o.last_tok)) begin
      res_d.last = 1'b1;
      if (cnt_q == '0) begin
        res_d.matches_path = (auth_cnt_q == '0);
      end else begin
        res_d.chosen_branch     = BRANCH_W'(best_q);
        res_d.accepted_depth    = DEPTH_OUT_W'(best_len_q);
        res_d.rejected_branches = BRANCH_W'(cnt_q - CNT_W'(1));
        res_d.found_match       = (best_len_q != '0);
        res_d.has_fallback      = cmd_i.emit_tok && fb_q;
        res_d.matches_path      = cmd_i.emit_sum || (total_q <= auth_cnt_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blim_q      <= BLIMIT_RST;
      dlim_q      <= DLIMIT_RST;
      lens_q      <= '{default: '0};
      auth_cnt_q  <= '0;
      cnt_q       <= '0;
      b_q         <= '0;
      p_q         <= '0;
      lim_q       <= '0;
      best_q      <= '0;
      best_len_q  <= '0;
      best_blen_q <= '0;
      i_q         <= '0;
      total_q     <= '0;
      fb_q        <= 1'b0;
      strobe_q    <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit_tok || cmd_i.emit_sum;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_BRANCH_LIMIT) begin
          blim_q <= cfg_wdata_i[BLIMIT_W-1:0];
        end
        if (cfg_idx_i == REG_DEPTH_LIMIT) begin
          dlim_q <= cfg_wdata_i[DLIMIT_W-1:0];
        end
      end
      if (draft_we) begin
        lens_q[lens_idx] <= lens_rd + LEN_W'(1);
      end
      if (auth_we) begin
        auth_cnt_q <= auth_cnt_q + LEN_W'(1);
      end
      if (cmd_i.vstart) begin
        cnt_q      <= cnt_in;
        b_q        <= '0;
        best_q     <= '0;
        best_len_q <= '0;
      end
      if (cmd_i.br_start) begin
        p_q   <= '0;
        lim_q <= lim_c;
        if (b_q == '0) begin
          best_blen_q <= lens_rd;
        end
      end
      if (cmd_i.p_inc) begin
        p_q <= p_q + LEN_W'(1);
      end
      if (cmd_i.br_end) begin
        if (p_q > best_len_q) begin
          best_q      <= b_q[BIDX_W-1:0];
          best_len_q  <= p_q;
          best_blen_q <= lens_rd;
        end
        b_q <= b_q + CNT_W'(1);
      end
      if (cmd_i.sum) begin
        fb_q    <= fb_c;
        total_q <= total_c;
        i_q     <= '0;
      end
      if (cmd_i.emit_tok) begin
        i_q <= i_q + LEN_W'(1);
      end
      if (cmd_i.clear) begin
        lens_q     <= '{default: '0};
        auth_cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o        = res_q;
  assign res_strobe_o = strobe_q;

endmodule

// ----- src/draft_tree_prefix_verifier.sv -----
// draft-tree prefix verifier: loads are accepted back to back while busy stays low
// verify: walks each branch comparing draft against authoritative tokens, keeps the
//   longest matched prefix, then emits the committed tokens; one result per strobe
// the walk goes through the single read port of the draft and authoritative memories
// reset: limits 8 and 16, branch lengths and authoritative count cleared, no sweep
// results are strobed for one cycle and cannot be stalled by the receiver
`timescale 1ns / 1ps
module draft_tree_prefix_verifier import dtpv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command side
  input  logic                 start,
  output logic                 busy,
  input  in_t                  in_i,
  // register write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // results, one result word per strobe
  output out_t                 res_o,
  output logic                 res_strobe_o
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: accepts transactions, walks branches and depths, drives emission
  dtpv_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .action_i (in_i.action),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  // datapath: limits, token memories, length table, prefix counters, result register
  dtpv_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_i         (in_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .res_o        (res_o),
    .res_strobe_o (res_strobe_o)
  );

endmodule

// ----- src/dtpv_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dtpv_checker import dtpv_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input in_t  in_i,
  input out_t res_o,
  input logic res_strobe_o
);

  // a verify transaction makes the block busy
  `DTPV_ASSERT_NEXT(a_verify_busy, clk_i, rst_ni, start && !busy && in_i.action == ACT_VERIFY, busy)
  // more results follow a non-final one, so the block stays busy
  `DTPV_ASSERT_NEXT(a_mid_busy, clk_i, rst_ni, res_strobe_o && !res_o.last, busy)
  // the final result frees the block in the same cycle
  `DTPV_ASSERT_NOW(a_last_free, clk_i, rst_ni, res_strobe_o && res_o.last, !busy)
  // a result without a token is the single final one and carries token zero
  `DTPV_ASSERT_NOW(a_empty_last, clk_i, rst_ni, res_strobe_o && !res_o.token_valid, res_o.last && res_o.token_out == '0)
  // token-only results carry no summary
  `DTPV_ASSERT_NOW(a_mid_nosum, clk_i, rst_ni, res_strobe_o && !res_o.last, res_o.chosen_branch == '0 && res_o.accepted_depth == '0 && res_o.rejected_branches == '0 && !res_o.found_match && !res_o.has_fallback && !res_o.matches_path)

endmodule

bind draft_tree_prefix_verifier dtpv_checker u_dtpv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .in_i         (in_i),
  .res_o        (res_o),
  .res_strobe_o (res_strobe_o)
);
